// ===== rtl/bounded_queue_service_monitor_macros.svh =====
// assertion macros used by the checker of the queue service monitor
// no dependencies
`ifndef BOUNDED_QUEUE_SERVICE_MONITOR_MACROS_SVH
`define BOUNDED_QUEUE_SERVICE_MONITOR_MACROS_SVH

// property holds at every clock edge outside reset
`define BQSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define BQSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bqsm_pkg.sv =====
// shared types and constants for the bounded queue service monitor
// no dependencies
package bqsm_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned CountW        = 5;
  localparam int unsigned StampW        = 32;
  localparam int unsigned StimeW        = 4;
  localparam int unsigned SumW          = 48;
  localparam int unsigned InDataW       = 8;
  localparam int unsigned OutDataW      = 232;

  localparam logic [CountW-1:0] LimitReset = 5'd10;

  // one waiting client
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [StimeW-1:0] stime;
  } entry_t;

endpackage

// ===== rtl/bqsm_store.sv =====
// waiting line storage: one write port, one registered read port with write forwarding
// depends on bqsm_pkg
module bqsm_store
  import bqsm_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bounded_queue_service_monitor.sv =====
// bounded queue service monitor: one input transaction is one tick of a single-server line
// a result is registered and valid in the cycle after its input transaction is accepted
// one transaction per cycle unless m_tready stalls, set by the registered next-head read
// reset: asynchronous active low, clears pointers, counters, totals and valid; limit goes to 10
// the line storage has no reset and needs no clearing pass
// depends on bqsm_pkg and bqsm_store
module bounded_queue_service_monitor
  import bqsm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,   // queue_limit
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,       // arrival_present, service_ticks, zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata        // arrival_accepted, arrival_rejected,
                                             // service_started, served_wait, queue_length,
                                             // total_accepted, total_rejected, total_served,
                                             // total_wait, total_queue_length
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CountW-1:0] LimitCap =
    CountW'((QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [StampW-1:0] Max32 = '1;
  localparam logic [SumW-1:0]   Max48 = '1;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  logic [CountW-1:0] limit_q;
  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CountW-1:0] count_q, count_d, count_mid;
  logic [StimeW-1:0] busy_q, busy_d, busy_mid;
  logic [StampW-1:0] tick_q;
  logic [StampW-1:0] acc_cnt_q, acc_cnt_d, rej_cnt_q, rej_cnt_d, srv_cnt_q, srv_cnt_d;
  logic [SumW-1:0]   wait_sum_q, wait_sum_d, len_sum_q, len_sum_d;
  logic              m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q, m_tdata_d;

  logic              in_acc, arrive, push, rej, pop;
  logic [StimeW-1:0] stime;
  logic [CountW-1:0] eff_limit;
  logic [StampW-1:0] wait_val;
  logic [SumW:0]     wait_sum_add, len_sum_add;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_entry, front, new_entry;

  assign s_tready = !m_tvalid_q || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign arrive   = s_tdata[0];
  assign stime    = s_tdata[StimeW:1];

  assign eff_limit = (limit_q < LimitCap) ? limit_q : LimitCap;
  assign new_entry = '{stamp: tick_q, stime: stime};

  always_comb begin
    push      = arrive && (count_q < eff_limit);
    rej       = arrive && !push;
    count_mid = count_q + CountW'(push);
    // an arrival into an empty line is served straight from the input when the server is idle
    front     = (count_q == '0) ? new_entry : rd_entry;
    pop       = (busy_q == '0) && (count_mid != '0);
    wait_val  = pop ? (tick_q - front.stamp) : '0;
    busy_mid  = pop ? front.stime : busy_q;
    busy_d    = (busy_mid != '0) ? busy_mid - 1'b1 : '0;
    count_d   = count_mid - CountW'(pop);
    head_d    = pop ? next_idx(head_q) : head_q;
    tail_d    = push ? next_idx(tail_q) : tail_q;

    acc_cnt_d = (push && (acc_cnt_q != Max32)) ? acc_cnt_q + 1'b1 : acc_cnt_q;
    rej_cnt_d = (rej && (rej_cnt_q != Max32)) ? rej_cnt_q + 1'b1 : rej_cnt_q;
    srv_cnt_d = (pop && (srv_cnt_q != Max32)) ? srv_cnt_q + 1'b1 : srv_cnt_q;

    wait_sum_add = {1'b0, wait_sum_q} + (SumW+1)'(wait_val);
    wait_sum_d   = wait_sum_add[SumW] ? Max48 : wait_sum_add[SumW-1:0];
    len_sum_add  = {1'b0, len_sum_q} + (SumW+1)'(count_d);
    len_sum_d    = len_sum_add[SumW] ? Max48 : len_sum_add[SumW-1:0];

    m_tdata_d = {len_sum_d, wait_sum_d, srv_cnt_d, rej_cnt_d, acc_cnt_d,
                 count_d, wait_val, pop, rej, push};
  end

  // keep the read register pointed at the head for the next tick
  assign rd_addr = in_acc ? head_d : head_q;

  bqsm_store #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && push),
    .waddr_i (tail_q),
    .wdata_i (new_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      busy_q     <= '0;
      tick_q     <= '0;
      acc_cnt_q  <= '0;
      rej_cnt_q  <= '0;
      srv_cnt_q  <= '0;
      wait_sum_q <= '0;
      len_sum_q  <= '0;
    end else if (in_acc) begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      busy_q     <= busy_d;
      tick_q     <= tick_q + 1'b1;
      acc_cnt_q  <= acc_cnt_d;
      rej_cnt_q  <= rej_cnt_d;
      srv_cnt_q  <= srv_cnt_d;
      wait_sum_q <= wait_sum_d;
      len_sum_q  <= len_sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (in_acc) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_tdata_q <= m_tdata_d;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/bqsm_checker.sv =====
// port-level checks for the bounded queue service monitor, bound to the top level
// depends on bqsm_pkg and bounded_queue_service_monitor_macros.svh
`include "bounded_queue_service_monitor_macros.svh"

module bqsm_checker
  import bqsm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  // an arrival is either accepted or turned away, never both
  `BQSM_ASSERT(a_acc_rej_excl, clk_i, rst_ni, !(m_tvalid && m_tdata[0] && m_tdata[1]), "accepted and rejected together")

  // no service start means no recorded wait
  `BQSM_ASSERT(a_wait_zero, clk_i, rst_ni, !(m_tvalid && !m_tdata[2] && (m_tdata[34:3] != '0)), "wait without service start")

  // an empty output register never back-pressures the input
  `BQSM_ASSERT(a_ready_when_empty, clk_i, rst_ni, m_tvalid || s_tready, "input stalled with empty output")

  // a stalled result holds
  `BQSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind bounded_queue_service_monitor bqsm_checker u_bqsm_checker (.*);
